FILE: sv/mvsm_pkg.sv
// ============================================================================
// mvsm_pkg: shared constants and types for the voice mixer
// Holds the opcode encodings, field widths and the per-voice record layout.
// ============================================================================
package mvsm_pkg;

    localparam int VOICES    = 8;
    localparam int VIDX_W    = $clog2(VOICES);
    localparam int ADDR_BITS = 16;
    localparam int POS_W     = 17;
    localparam int CLAMP     = 32000;

    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_START = 2'd1;
    localparam logic [1:0] OP_MIX   = 2'd2;

    typedef struct packed {
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] fin;
        logic [15:0]      frac;
        logic [17:0]      step;
        logic [7:0]       lgain;
        logic [7:0]       rgain;
        logic [7:0]       sid;
        logic [30:0]      tick;
    } t_voice;

endpackage

FILE: sv/mvsm_gain.sv
// ============================================================================
// mvsm_gain: two-stage gain calculation for one stereo channel
// Computes vol - (vol*d^2 >> 16), then scales it by 240/128.
// ============================================================================
module mvsm_gain
    import mvsm_pkg::*;
(
    input  logic       i_clk,
    input  logic [6:0] i_vol,
    input  logic [8:0] i_mag,
    output logic [7:0] o_gain
);

    logic [17:0] w_sq;
    logic [17:0] r_sq;
    logic [6:0]  r_vol;
    logic [24:0] w_prod;
    logic [6:0]  w_g;
    logic [14:0] w_mul;

    // The square of the distance is at most 256*256, so it fits 17 bits.
    assign w_sq = 18'(i_mag) * 18'(i_mag);

    always_ff @(posedge i_clk) begin
        r_sq  <= w_sq;
        r_vol <= i_vol;
    end

    assign w_prod = 25'(r_vol) * 25'(r_sq);
    assign w_g    = r_vol - w_prod[22:16];
    assign w_mul  = 15'(w_g) * 15'd240;
    assign o_gain = w_mul[14:7];

endmodule

FILE: sv/multi_voice_sample_mixer_top.sv
// ----------------------------------------------------------------------------
// One word in flight at a time: a new word is taken only once the last one is
// done and its result is not held by an output stall. A mix walks the voice
// table one voice at a time (table read, sample memory read, accumulate and
// write back).
// Voice activity and the handle counter clear on reset; the voice table
// contents are gated by the active bits, and sample memory is not cleared.
// ----------------------------------------------------------------------------
// ============================================================================
// multi_voice_sample_mixer_top: eight-voice wavetable sample mixer
// Voice records live in a small synchronous table, samples in a 64K memory.
// ============================================================================
module multi_voice_sample_mixer_top
    import mvsm_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic [15:0]        i_address,
    input  logic [7:0]         i_sample_byte,
    input  logic [16:0]        i_length,
    input  logic [7:0]         i_sound_id,
    input  logic               i_exclusive,
    input  logic [6:0]         i_volume,
    input  logic [7:0]         i_separation,
    input  logic [17:0]        i_pitch_step,
    input  logic [30:0]        i_game_tick,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_left_sample,
    output logic signed [15:0] o_right_sample,
    output logic [15:0]        o_handle,
    output logic [2:0]         o_voice_used
);

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_GAIN, S_VREAD, S_SREAD, S_MACC, S_DONE
    } t_state;

    t_state            r_state;
    logic [1:0]        r_op;
    logic [15:0]       r_addr;
    logic [16:0]       r_len;
    logic [7:0]        r_sid;
    logic              r_excl;
    logic [6:0]        r_vol;
    logic [7:0]        r_sep;
    logic [17:0]       r_pstep;
    logic [30:0]       r_tick;
    logic [VOICES-1:0] r_active;
    logic [30:0]       r_vtick [VOICES];
    logic [7:0]        r_vsid  [VOICES];
    logic [15:0]       r_next_handle;
    logic [VIDX_W:0]   r_vi;
    logic [VIDX_W-1:0] r_slot;
    logic signed [19:0] r_lacc;
    logic signed [19:0] r_racc;
    t_voice            r_vrec;

    t_voice            voice_mem [VOICES];
    logic [7:0]        sample_mem [2**ADDR_BITS];
    t_voice            r_vrd;
    logic [7:0]        r_srd;

    logic [7:0]        w_lgain, w_rgain;
    logic [8:0]        w_lmag, w_rmag;

    // A finished result that is still waiting also holds off the next word.
    assign o_stall = (r_state != S_IDLE) || (o_valid && i_stall);

    // Distance terms: sep+1 for left, 256-sep for right (sign is squared away).
    assign w_lmag = {1'b0, r_sep} + 9'd1;
    assign w_rmag = 9'd256 - {1'b0, r_sep};

    mvsm_gain u_lgain (.i_clk(i_clk), .i_vol(r_vol), .i_mag(w_lmag), .o_gain(w_lgain));
    mvsm_gain u_rgain (.i_clk(i_clk), .i_vol(r_vol), .i_mag(w_rmag), .o_gain(w_rgain));

    // Slot selection works on the flop copies of id, tick and active bits.
    logic [VIDX_W-1:0] w_slot;
    logic [VOICES-1:0] w_act_after;
    always_comb begin
        logic [30:0] oldest;
        logic        found, done;
        w_act_after = r_active;
        done = 1'b0;
        if (r_excl) begin
            for (int k = 0; k < VOICES; k++) begin
                if (!done && r_active[k] && r_vsid[k] == r_sid) begin
                    w_act_after[k] = 1'b0;
                    done = 1'b1;
                end
            end
        end
        oldest = r_tick;
        w_slot = '0;
        found  = 1'b0;
        for (int k = 0; k < VOICES; k++) begin
            if (!found) begin
                if (!w_act_after[k]) begin
                    w_slot = VIDX_W'(k);
                    found  = 1'b1;
                end else if (r_vtick[k] < oldest) begin
                    oldest = r_vtick[k];
                    w_slot = VIDX_W'(k);
                end
            end
        end
    end

    // Voice advance for the record read back from the table.
    logic signed [16:0] w_s;
    logic signed [16:0] w_lprod, w_rprod;
    assign w_s     = $signed({9'b0, r_srd}) - 17'sd128;
    assign w_lprod = w_s * $signed({9'b0, r_vrd.lgain});
    assign w_rprod = w_s * $signed({9'b0, r_vrd.rgain});

    // The end test uses one extra bit so a position past the top cannot wrap.
    logic [18:0] w_fs_full;
    assign w_fs_full = 19'(r_vrd.frac) + 19'(r_vrd.step);
    logic [POS_W:0]   w_adv_full;
    logic [POS_W-1:0] w_adv_pos;
    assign w_adv_full = {1'b0, r_vrd.pos} + (POS_W+1)'(w_fs_full[18:16]);
    assign w_adv_pos  = w_adv_full[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        r_vrd <= voice_mem[r_vi[VIDX_W-1:0]];
        r_srd <= sample_mem[r_vrd.pos[ADDR_BITS-1:0]];
        if (i_valid && !o_stall && i_op == OP_WRITE) begin
            sample_mem[i_address] <= i_sample_byte;
        end
        if (r_state == S_DONE && r_op == OP_START) begin
            voice_mem[r_slot] <= r_vrec;
        end else if (r_state == S_MACC) begin
            t_voice v;
            v      = r_vrd;
            v.pos  = w_adv_pos;
            v.frac = w_fs_full[15:0];
            voice_mem[r_vi[VIDX_W-1:0]] <= v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_active      <= '0;
            r_next_handle <= '0;
            o_valid       <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_valid && !i_stall) o_valid <= 1'b0;
                    if (i_valid && !o_stall) begin
                        r_op    <= i_op;
                        r_addr  <= i_address;
                        r_len   <= i_length;
                        r_sid   <= i_sound_id;
                        r_excl  <= i_exclusive;
                        r_vol   <= i_volume;
                        r_sep   <= i_separation;
                        r_pstep <= i_pitch_step;
                        r_tick  <= i_game_tick;
                        r_vi    <= '0;
                        r_lacc  <= '0;
                        r_racc  <= '0;
                        if (i_op == OP_START) r_state <= S_START;
                        else if (i_op == OP_MIX) r_state <= S_VREAD;
                        else r_state <= S_DONE;
                    end
                end
                S_START: begin
                    r_slot  <= w_slot;
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    r_vrec.pos   <= {1'b0, r_addr};
                    r_vrec.fin   <= {1'b0, r_addr} +
                                    ((r_len > 17'd65536) ? 17'd65536 : r_len);
                    r_vrec.frac  <= '0;
                    r_vrec.step  <= r_pstep;
                    r_vrec.lgain <= w_lgain;
                    r_vrec.rgain <= w_rgain;
                    r_vrec.sid   <= r_sid;
                    r_vrec.tick  <= r_tick;
                    r_active     <= w_act_after;
                    r_state      <= S_DONE;
                end
                S_VREAD: begin
                    // Table read issued this cycle; data is in r_vrd next.
                    r_state <= S_SREAD;
                end
                S_SREAD: begin
                    r_state <= S_MACC;
                end
                S_MACC: begin
                    if (r_active[r_vi[VIDX_W-1:0]]) begin
                        r_lacc <= r_lacc + 20'(w_lprod);
                        r_racc <= r_racc + 20'(w_rprod);
                        if (w_adv_full >= {1'b0, r_vrd.fin}) begin
                            r_active[r_vi[VIDX_W-1:0]] <= 1'b0;
                        end
                    end
                    r_vi <= r_vi + 1'b1;
                    if (r_vi == (VIDX_W+1)'(VOICES-1)) r_state <= S_DONE;
                    else r_state <= S_VREAD;
                end
                S_DONE: begin
                    o_valid <= 1'b1;
                    if (r_op == OP_START) begin
                        r_active[r_slot] <= 1'b1;
                        r_vsid[r_slot]   <= r_sid;
                        r_vtick[r_slot]  <= r_tick;
                        o_left_sample    <= '0;
                        o_right_sample   <= '0;
                        o_handle         <= (r_next_handle == 16'd0) ? 16'd100 : r_next_handle;
                        r_next_handle    <= ((r_next_handle == 16'd0) ? 16'd100
                                             : r_next_handle) + 16'd1;
                        o_voice_used     <= 3'(r_slot);
                    end else if (r_op == OP_MIX) begin
                        o_left_sample  <= (r_lacc > 20'sd32000) ? 16'sd32000 :
                                          (r_lacc < -20'sd32000) ? -16'sd32000 : 16'(r_lacc);
                        o_right_sample <= (r_racc > 20'sd32000) ? 16'sd32000 :
                                          (r_racc < -20'sd32000) ? -16'sd32000 : 16'(r_racc);
                        o_handle       <= '0;
                        o_voice_used   <= '0;
                    end else begin
                        o_left_sample  <= '0;
                        o_right_sample <= '0;
                        o_handle       <= '0;
                        o_voice_used   <= '0;
                    end
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_stall_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> o_stall) else $error("busy without stall");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall && r_state == S_IDLE) |=> o_valid)
        else $error("result dropped");
    a_handle_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_handle != 16'd0) |-> (o_left_sample == 16'sd0))
        else $error("start result carries mix data");

endmodule

FILE: tb/multi_voice_sample_mixer_top_tb.sv
`timescale 1ns / 1ps
// ============================================================================
// multi_voice_sample_mixer_top_tb: self-checking bench for the voice mixer
// Fills the sample region that sounds play from, then runs directed and
// random write, start, mix and no-op words with random sender gaps and
// receiver stalls. Every result word is checked against a built-in model.
// ============================================================================
module multi_voice_sample_mixer_top_tb;
    import mvsm_pkg::*;

    localparam logic [1:0] OP_NOP = 2'd3;
    localparam int IDLE_LIMIT     = 5000;
    localparam int FILL_BYTES     = 256;
    localparam int START_ADDR_MAX = 190;
    localparam int RANDOM_WORDS   = 720;

    typedef struct {
        logic [1:0]  op;
        logic [15:0] address;
        logic [7:0]  sample_byte;
        logic [16:0] length;
        logic [7:0]  sound_id;
        logic        exclusive;
        logic [6:0]  volume;
        logic [7:0]  separation;
        logic [17:0] pitch_step;
        logic [30:0] game_tick;
        bit          drain;
    } t_mix_word;

    typedef struct {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic [15:0]        handle;
        logic [2:0]         voice;
    } t_mix_result;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_valid;
    logic               o_stall;
    logic [1:0]         i_op;
    logic [15:0]        i_address;
    logic [7:0]         i_sample_byte;
    logic [16:0]        i_length;
    logic [7:0]         i_sound_id;
    logic               i_exclusive;
    logic [6:0]         i_volume;
    logic [7:0]         i_separation;
    logic [17:0]        i_pitch_step;
    logic [30:0]        i_game_tick;
    logic               o_valid;
    logic               i_stall;
    logic signed [15:0] o_left_sample;
    logic signed [15:0] o_right_sample;
    logic [15:0]        o_handle;
    logic [2:0]         o_voice_used;

    multi_voice_sample_mixer_top DUT (.*);

    // Model state of the mixer.
    logic [7:0]  sample_mem [0:65535];
    bit          v_on    [VOICES];
    int unsigned v_pos   [VOICES];
    int unsigned v_end   [VOICES];
    int unsigned v_frac  [VOICES];
    int unsigned v_step  [VOICES];
    int unsigned v_lgain [VOICES];
    int unsigned v_rgain [VOICES];
    int unsigned v_sid   [VOICES];
    int unsigned v_tick  [VOICES];
    logic [15:0] next_handle;

    t_mix_word   word_queue [$];
    t_mix_result expected_frames [$];
    t_mix_word   drv_w;
    bit          word_taken;
    int          gap_left, burst_left, idle_cycles, cyc;
    int          errors, n_write, n_start, n_mix, n_nop, n_clamp, n_checked;
    int unsigned tick_now;

    function automatic int unsigned voice_gain(int unsigned vol, int s);
        int unsigned sq;
        int unsigned g;
        sq = s * s;
        g = vol - ((vol * sq) >> 16);
        return (g * 240) >> 7;
    endfunction

    function automatic int clamp_sum(int v);
        if (v > CLAMP || v < -CLAMP) n_clamp++;
        if (v > CLAMP) return CLAMP;
        if (v < -CLAMP) return -CLAMP;
        return v;
    endfunction

    task automatic predict_word(input t_mix_word w);
        t_mix_result r;
        int          k, slot, oldest_idx, s, lsum, rsum;
        int unsigned oldest, len, f;
        r = '{0, 0, 0, 0};
        case (w.op)
            OP_WRITE: begin
                sample_mem[w.address] = w.sample_byte;
                n_write++;
            end
            OP_START: begin
                n_start++;
                if (w.exclusive) begin
                    for (k = 0; k < VOICES; k++) begin
                        if (v_on[k] && v_sid[k] == w.sound_id) begin
                            v_on[k] = 0;
                            break;
                        end
                    end
                end
                oldest = w.game_tick;
                oldest_idx = 0;
                for (k = 0; k < VOICES && v_on[k]; k++) begin
                    if (v_tick[k] < oldest) begin
                        oldest = v_tick[k];
                        oldest_idx = k;
                    end
                end
                slot = (k == VOICES) ? oldest_idx : k;
                len = (w.length > 65536) ? 65536 : w.length;
                v_on[slot]    = 1;
                v_pos[slot]   = w.address;
                v_end[slot]   = w.address + len;
                v_step[slot]  = w.pitch_step;
                v_frac[slot]  = 0;
                v_tick[slot]  = w.game_tick;
                v_lgain[slot] = voice_gain(w.volume, int'(w.separation) + 1);
                v_rgain[slot] = voice_gain(w.volume, int'(w.separation) + 1 - 257);
                v_sid[slot]   = w.sound_id;
                if (next_handle == 0) next_handle = 100;
                r.handle = next_handle;
                next_handle = next_handle + 1;
                r.voice = slot[2:0];
            end
            OP_MIX: begin
                n_mix++;
                lsum = 0;
                rsum = 0;
                for (k = 0; k < VOICES; k++) begin
                    if (v_on[k]) begin
                        s = int'(sample_mem[v_pos[k][15:0]]) - 128;
                        lsum += int'(v_lgain[k]) * s;
                        rsum += int'(v_rgain[k]) * s;
                        f = v_frac[k] + v_step[k];
                        v_pos[k] += f >> 16;
                        v_frac[k] = f & 32'hFFFF;
                        if (v_pos[k] >= v_end[k]) v_on[k] = 0;
                    end
                end
                r.left  = 16'(clamp_sum(lsum));
                r.right = 16'(clamp_sum(rsum));
            end
            default: n_nop++;
        endcase
        expected_frames.push_back(r);
    endtask

    // All fields random; start words get a bounded address and length here, and the caller may set more.
    // Random sounds start and end inside the filled region.
    function automatic t_mix_word rand_word(logic [1:0] op);
        t_mix_word w;
        w.op          = op;
        w.address     = 16'($urandom_range(0, FILL_BYTES - 1));
        w.sample_byte = 8'($urandom);
        w.length      = 17'($urandom);
        w.sound_id    = 8'($urandom_range(0, 7));
        w.exclusive   = 1'($urandom);
        w.volume      = 7'($urandom);
        w.separation  = 8'($urandom);
        w.pitch_step  = 18'($urandom);
        tick_now     += $urandom_range(0, 50);
        w.game_tick   = ($urandom_range(0, 19) == 0) ? 31'($urandom) : 31'(tick_now);
        w.drain       = 0;
        if (op == OP_START) begin
            w.address = 16'($urandom_range(0, START_ADDR_MAX));
            case ($urandom_range(0, 9))
                0:       w.length = 0;
                default: w.length = 17'($urandom_range(1, 64));
            endcase
            if ($urandom_range(0, 3) != 0)
                w.pitch_step = 18'($urandom_range(16'h2000, 18'h30000));
        end
        return w;
    endfunction

    function automatic t_mix_word start_word(int sid, int vol, int sep, int len,
                                             int tk, bit excl);
        t_mix_word w;
        w = rand_word(OP_START);
        w.sound_id   = 8'(sid);
        w.volume     = 7'(vol);
        w.separation = 8'(sep);
        w.length     = 17'(len);
        w.game_tick  = 31'(tk);
        w.exclusive  = excl;
        return w;
    endfunction

    always #4 i_clk = ~i_clk;

    // Sender: bursts of words separated by random gaps.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 0;
        end else if (!i_valid || word_taken) begin
            if (gap_left > 0) begin
                i_valid  <= 0;
                gap_left <= gap_left - 1;
            end else if (word_queue.size() > 0 &&
                         !(word_queue[0].drain && expected_frames.size() > 0)) begin
                drv_w = word_queue.pop_front();
                i_op          <= drv_w.op;
                i_address     <= drv_w.address;
                i_sample_byte <= drv_w.sample_byte;
                i_length      <= drv_w.length;
                i_sound_id    <= drv_w.sound_id;
                i_exclusive   <= drv_w.exclusive;
                i_volume      <= drv_w.volume;
                i_separation  <= drv_w.separation;
                i_pitch_step  <= drv_w.pitch_step;
                i_game_tick   <= drv_w.game_tick;
                i_valid       <= 1;
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 24);
                    gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                i_valid <= 0;
            end
        end
    end

    // Receiver: the stall density changes with bits 9:8 of the cycle counter.
    always @(negedge i_clk) begin
        cyc     <= cyc + 1;
        i_stall <= i_rst_n && ($urandom_range(0, 3) < cyc[9:8]);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            word_taken  <= 0;
            idle_cycles <= 0;
        end else begin
            word_taken <= i_valid && !o_stall;
            if (o_valid && !i_stall) begin
                if (expected_frames.size() == 0) begin
                    $display("%0t: result word with nothing expected: L=%0d R=%0d H=%0d V=%0d",
                             $time, o_left_sample, o_right_sample, o_handle, o_voice_used);
                    errors++;
                end else begin
                    t_mix_result e;
                    e = expected_frames.pop_front();
                    n_checked++;
                    if (o_left_sample !== e.left) begin
                        $display("%0t: left_sample expected %0d got %0d",
                                 $time, e.left, o_left_sample);
                        errors++;
                    end
                    if (o_right_sample !== e.right) begin
                        $display("%0t: right_sample expected %0d got %0d",
                                 $time, e.right, o_right_sample);
                        errors++;
                    end
                    if (o_handle !== e.handle) begin
                        $display("%0t: handle expected %0d got %0d", $time, e.handle, o_handle);
                        errors++;
                    end
                    if (o_voice_used !== e.voice) begin
                        $display("%0t: voice_used expected %0d got %0d",
                                 $time, e.voice, o_voice_used);
                        errors++;
                    end
                end
            end
            if (i_valid && !o_stall) begin
                predict_word('{i_op, i_address, i_sample_byte, i_length, i_sound_id,
                               i_exclusive, i_volume, i_separation, i_pitch_step,
                               i_game_tick, 1'b0});
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("[multi_voice_sample_mixer_top] ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial begin
        t_mix_word w;
        int        k, pick;
        i_clk = 0; i_rst_n = 0; i_valid = 0; i_stall = 0;
        i_op = 0; i_address = 0; i_sample_byte = 0; i_length = 0; i_sound_id = 0;
        i_exclusive = 0; i_volume = 0; i_separation = 0; i_pitch_step = 0;
        i_game_tick = 0;
        cyc = 0; gap_left = 0; burst_left = 8; word_taken = 0; tick_now = 1000;
        errors = 0; n_write = 0; n_start = 0; n_mix = 0; n_nop = 0; n_clamp = 0;
        n_checked = 0; next_handle = 0;
        foreach (v_on[k]) begin
            v_on[k] = 0; v_pos[k] = 0; v_end[k] = 0; v_frac[k] = 0; v_step[k] = 0;
            v_lgain[k] = 0; v_rgain[k] = 0; v_sid[k] = 0; v_tick[k] = 0;
        end

        // The sample region that sounds play from is written first, so no
        // voice ever reads an unwritten byte.
        for (k = 0; k < FILL_BYTES; k++) begin
            w = rand_word(OP_WRITE);
            w.address = 16'(k);
            if (k < 64) w.sample_byte = (k % 2 == 0) ? 8'd255 : 8'd0;
            word_queue.push_back(w);
        end

        // Directed part: gains at the stereo extremes, clamping, zero and long
        // length, exclusive replacement, oldest-voice reuse and a no-op.
        // Long sounds are stopped after a few frames so they stay in the region.
        w = rand_word(OP_NOP);
        word_queue.push_back(w);
        for (k = 0; k < 8; k++) begin
            w = start_word(k, 127, (k % 2) ? 255 : 0, 40, 500 + k, 0);
            w.address = 16'(k % 2 * 2);
            w.pitch_step = 18'h20000;
            word_queue.push_back(w);
        end
        for (k = 0; k < 3; k++) word_queue.push_back(rand_word(OP_MIX));
        word_queue.push_back(start_word(3, 0, 128, 0, 600, 1));
        word_queue.push_back(start_word(9, 127, 128, 131071, 400, 0));
        word_queue.push_back(rand_word(OP_MIX));
        word_queue.push_back(start_word(9, 64, 200, 17, 31'h7FFFFFFF, 1));
        word_queue.push_back(start_word(4, 127, 0, 65536, 0, 0));
        w = rand_word(OP_MIX);
        w.drain = 1;
        word_queue.push_back(w);
        for (k = 0; k < 3; k++) word_queue.push_back(rand_word(OP_MIX));
        word_queue.push_back(start_word(4, 100, 50, 10, 700, 1));

        // Random part, with a full drain now and then.
        for (k = 0; k < RANDOM_WORDS; k++) begin
            pick = $urandom_range(0, 9);
            if (pick < 4)      w = rand_word(OP_MIX);
            else if (pick < 7) w = rand_word(OP_START);
            else if (pick < 9) w = rand_word(OP_WRITE);
            else               w = rand_word(OP_NOP);
            w.drain = (k % 250 == 125);
            word_queue.push_back(w);
        end

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1;

        do begin
            @(posedge i_clk);
            #1;
        end while (word_queue.size() > 0 || i_valid || expected_frames.size() > 0);
        repeat (40) @(posedge i_clk);

        $display("Covered %0d writes, %0d starts, %0d mixes, %0d no-ops; %0d results checked.",
                 n_write, n_start, n_mix, n_nop, n_checked);
        $display("Clamped channel sums seen: %0d.", n_clamp);
        if (errors == 0 && expected_frames.size() == 0) begin
            $display("[multi_voice_sample_mixer_top] OK");
        end else begin
            $display("[multi_voice_sample_mixer_top] ERROR");
        end
        $finish;
    end

endmodule
